// ===== design/page_replacement_fifo_lru_top_macros.svh =====
// Assertion macros shared by the page replacement unit.
`ifndef PAGE_REPLACEMENT_FIFO_LRU_TOP_MACROS_SVH
`define PAGE_REPLACEMENT_FIFO_LRU_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define PRF_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Antecedent implies consequent in the following cycle.
`define PRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PRF_ASSERT_SAME(lbl, ante, cons, msg)
`define PRF_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== design/prf_pkg.sv =====
// Shared types and constants for the page replacement unit.
package prf_pkg;

    localparam int MAX_FRAMES_DEF = 16;
    localparam int PAGE_BITS_DEF  = 8;

    localparam int FAULT_W   = 16;
    localparam int FIU_W     = 5;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = FIU_W;

    localparam logic [FIU_W-1:0] FIU_RESET = 5'd16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES = 1'b1;

    // Replacement policy codes.
    localparam logic POLICY_FIFO = 1'b0;
    localparam logic POLICY_LRU  = 1'b1;

    typedef struct packed {
        logic load;
        logic exec;
    } prf_cmd_t;

    typedef struct packed {
        logic out_free;
    } prf_status_t;

endpackage

// ===== design/prf_ctrl.sv =====
// Sequencing controller: accepts a reference, then runs one lookup and update step.
module prf_ctrl import prf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  prf_status_t status,
    output logic        in_stall,
    output prf_cmd_t    cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.load   = 1'b0;
        cmd.exec   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // The step waits until the output register can take its result.
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== design/prf_dp.sv =====
// Datapath: frame tags, valid bits, recency ranks, counters and the result register.
module prf_dp import prf_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [PAGE_BITS-1:0]  page_number,
    input  logic                  restart,
    input  prf_cmd_t              cmd,
    output prf_status_t           status,
    input  logic                  out_stall,
    output logic                  out_valid,
    output logic                  hit,
    output logic [SLOT_W-1:0]     slot,
    output logic                  evicted_valid,
    output logic [PAGE_BITS-1:0]  evicted_page,
    output logic [FAULT_W-1:0]    fault_count
);

    localparam int LIM_W  = $clog2(MAX_FRAMES + 1);
    localparam int RANK_W = SLOT_W;

    // Configuration.
    logic             policy_reg;
    logic [FIU_W-1:0] fiu_reg;

    // Frame state.
    logic [PAGE_BITS-1:0]  page_reg;
    logic [MAX_FRAMES-1:0] valid_reg, valid_next;
    logic [PAGE_BITS-1:0]  frame_page_reg [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_reg [MAX_FRAMES];
    logic [RANK_W-1:0]     rank_upd [MAX_FRAMES];
    logic [SLOT_W-1:0]     ptr_reg, ptr_next;
    logic [LIM_W-1:0]      filled_reg, filled_next;
    logic [FAULT_W-1:0]    fault_reg, fault_next, fault_upd;

    // Result register.
    logic                 out_valid_reg, out_valid_next;
    logic                 hit_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic                 ev_valid_reg;
    logic [PAGE_BITS-1:0] ev_page_reg;
    logic [FAULT_W-1:0]   fault_out_reg;

    // Step logic.
    logic [LIM_W-1:0]  limit;
    logic [LIM_W-1:0]  filled_m1;
    logic              hit_found;
    logic [SLOT_W-1:0] hit_slot;
    logic              lru_found;
    logic [SLOT_W-1:0] lru_slot;
    logic [LIM_W-1:0]  ptr_ext, ptr_eff, ptr_inc, ptr_wrap;
    logic              fill;
    logic              replace;
    logic [SLOT_W-1:0] slot_c;
    logic [RANK_W-1:0] old_rank;

    // A frame count of zero acts as one; a count above the frame set is clamped.
    always_comb
    begin
        if (fiu_reg == '0)
        begin
            limit = LIM_W'(1);
        end
        else if (int'(fiu_reg) > MAX_FRAMES)
        begin
            limit = LIM_W'(MAX_FRAMES);
        end
        else
        begin
            limit = LIM_W'(fiu_reg);
        end
    end

    assign filled_m1 = filled_reg - LIM_W'(1);

    // Tag match and least recent frame search across all frames at once.
    always_comb
    begin
        hit_found = 1'b0;
        hit_slot  = '0;
        lru_found = 1'b0;
        lru_slot  = '0;
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            if (!hit_found && valid_reg[i] && (frame_page_reg[i] == page_reg))
            begin
                hit_found = 1'b1;
                hit_slot  = SLOT_W'(i);
            end
            // Ranks of the filled frames are a permutation, so the oldest is unique.
            if (!lru_found && valid_reg[i] && (LIM_W'(rank_reg[i]) == filled_m1))
            begin
                lru_found = 1'b1;
                lru_slot  = SLOT_W'(i);
            end
        end
    end

    // Round-robin pointer wraps to frame zero when it is not below the fill count.
    assign ptr_ext  = LIM_W'(ptr_reg);
    assign ptr_eff  = (ptr_ext >= filled_reg) ? '0 : ptr_ext;
    assign ptr_inc  = ptr_eff + LIM_W'(1);
    assign ptr_wrap = (ptr_inc >= filled_reg) ? '0 : ptr_inc;

    assign fill    = !hit_found && (filled_reg < limit);
    assign replace = !hit_found && !fill;

    always_comb
    begin
        if (hit_found)
        begin
            slot_c = hit_slot;
        end
        else if (fill)
        begin
            slot_c = filled_reg[SLOT_W-1:0];
        end
        else if (policy_reg == POLICY_LRU)
        begin
            slot_c = lru_slot;
        end
        else
        begin
            slot_c = ptr_eff[SLOT_W-1:0];
        end
    end

    assign old_rank = rank_reg[slot_c];

    // The touched frame becomes most recent; frames that were more recent age by one.
    // A newly filled frame ages every other resident frame.
    always_comb
    begin
        for (int i = 0; i < MAX_FRAMES; i++)
        begin
            rank_upd[i] = rank_reg[i];
            if (SLOT_W'(i) == slot_c)
            begin
                rank_upd[i] = '0;
            end
            else if (valid_reg[i] && (fill || (rank_reg[i] < old_rank)))
            begin
                rank_upd[i] = rank_reg[i] + RANK_W'(1);
            end
        end
    end

    assign fault_upd = hit_found ? fault_reg :
                       ((fault_reg == '1) ? fault_reg : fault_reg + FAULT_W'(1));

    always_comb
    begin
        valid_next  = valid_reg;
        ptr_next    = ptr_reg;
        filled_next = filled_reg;
        fault_next  = fault_reg;
        if (cmd.load && restart)
        begin
            valid_next  = '0;
            ptr_next    = '0;
            filled_next = '0;
            fault_next  = '0;
        end
        else if (cmd.exec)
        begin
            fault_next = fault_upd;
            if (fill)
            begin
                valid_next[slot_c] = 1'b1;
                filled_next        = filled_reg + LIM_W'(1);
            end
            if (replace && (policy_reg == POLICY_FIFO))
            begin
                ptr_next = ptr_wrap[SLOT_W-1:0];
            end
        end
    end

    assign out_valid_next = cmd.exec || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POLICY_FIFO;
            fiu_reg       <= FIU_RESET;
            valid_reg     <= '0;
            ptr_reg       <= '0;
            filled_reg    <= '0;
            fault_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_POLICY: policy_reg <= cfg_data[0];
                    CFG_FRAMES: fiu_reg    <= cfg_data;
                    default:    fiu_reg    <= fiu_reg;
                endcase
            end
            valid_reg     <= valid_next;
            ptr_reg       <= ptr_next;
            filled_reg    <= filled_next;
            fault_reg     <= fault_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            page_reg <= page_number;
        end
        if (cmd.exec)
        begin
            if (!hit_found)
            begin
                frame_page_reg[slot_c] <= page_reg;
            end
            for (int i = 0; i < MAX_FRAMES; i++)
            begin
                rank_reg[i] <= rank_upd[i];
            end
            hit_reg       <= hit_found;
            slot_reg      <= slot_c;
            ev_valid_reg  <= replace;
            ev_page_reg   <= replace ? frame_page_reg[slot_c] : '0;
            fault_out_reg <= fault_upd;
        end
    end

    assign status.out_free = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign hit           = hit_reg;
    assign slot          = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = fault_out_reg;

endmodule

// ===== design/page_replacement_fifo_lru_top.sv =====
// Page replacement unit with first in first out and least recently used policies.
// Input channel: in_valid / in_stall carry page_number and restart. A transfer
// happens when in_valid is high and in_stall is low. A set restart clears all
// frames, the round-robin pointer, the fill count and the fault count
// before that reference is looked up; the two configuration registers are kept.
// Output channel: out_valid / out_stall carry hit, slot, evicted_valid,
// evicted_page and fault_count, one result for each reference.
// A reference is handled as the transfer edge, then one step that
// compares the page against every frame tag, picks the victim, updates the
// ranks and loads the result register. No new reference is taken until that
// step has run, and the step waits while a stalled result fills the register.
// This order is set by the controller's two-state sequence around the step.
// The result register parts the two channels: the next reference is taken
// while a result waits, and its step holds until the receiver drops out_stall.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); index
// 0 is the policy and index 1 the frame count. Write it only while idle.
// Reset clears all frames, sets the policy to first in first out and the frame
// count to sixteen; there is no clearing pass.
`include "page_replacement_fifo_lru_top_macros.svh"

module page_replacement_fifo_lru_top import prf_pkg::*;
#(
    parameter int MAX_FRAMES = MAX_FRAMES_DEF,
    parameter int PAGE_BITS  = PAGE_BITS_DEF,
    parameter int SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PAGE_BITS-1:0]  page_number,
    input  logic                  restart,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  hit,
    output logic [SLOT_W-1:0]     slot,
    output logic                  evicted_valid,
    output logic [PAGE_BITS-1:0]  evicted_page,
    output logic [FAULT_W-1:0]    fault_count
);

    prf_cmd_t    cmd;
    prf_status_t status;

    prf_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    prf_dp
    #(
        .MAX_FRAMES (MAX_FRAMES),
        .PAGE_BITS  (PAGE_BITS),
        .SLOT_W     (SLOT_W)
    )
    u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .page_number   (page_number),
        .restart       (restart),
        .cmd           (cmd),
        .status        (status),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .hit           (hit),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

    // A transfer in always leaves the block busy for its step.
    `PRF_ASSERT_NEXT(a_busy_after_load, in_valid && !in_stall, in_stall, "no step after load")
    // Every step delivers a result into the output register.
    `PRF_ASSERT_NEXT(a_exec_fills_out, cmd.exec, out_valid, "step lost its result")
    // A step never overwrites a result that is still stalled.
    `PRF_ASSERT_SAME(a_no_overwrite, cmd.exec, !out_valid || !out_stall, "result overwritten")
    // A taken result is gone unless a new step replaced it.
    `PRF_ASSERT_NEXT(a_no_repeat, out_valid && !out_stall && !cmd.exec, !out_valid,
                     "result repeated")

endmodule
